/* design/tbb_pkg.sv */
// ----------------------------------------------------------------------------
// tbb_pkg: shared types and constants of the transformed box bounds unit
// Request payloads, configuration register indexes, reset values and the
// fixed-point widths used by the datapath.
// ----------------------------------------------------------------------------
package tbb_pkg;

  localparam int CoordW     = 32;  // Q16.16 coordinates
  localparam int CoefW      = 16;  // Q2.14 coefficients
  localparam int CoefFrac   = 14;
  localparam int RowW       = 3 * CoefW;
  localparam int ProdW      = CoordW + CoefW;  // exact product width
  localparam int SumW       = ProdW + 2;       // three products plus offset
  localparam int ShiftedW   = SumW - CoefFrac;
  localparam int Axes       = 3;
  localparam int CfgIndexW  = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_ROW_X    = 3'd0,
    CFG_ROW_Y    = 3'd1,
    CFG_ROW_Z    = 3'd2,
    CFG_OFFSET_X = 3'd3,
    CFG_OFFSET_Y = 3'd4,
    CFG_OFFSET_Z = 3'd5
  } cfg_reg_t;

  // Identity transform after reset.
  localparam logic [RowW-1:0] RowXReset = 48'h0000_0000_4000;
  localparam logic [RowW-1:0] RowYReset = 48'h0000_4000_0000;
  localparam logic [RowW-1:0] RowZReset = 48'h4000_0000_0000;

  typedef struct packed {
    logic                     start_new;
    logic signed [CoordW-1:0] box_low_x;
    logic signed [CoordW-1:0] box_low_y;
    logic signed [CoordW-1:0] box_low_z;
    logic signed [CoordW-1:0] box_high_x;
    logic signed [CoordW-1:0] box_high_y;
    logic signed [CoordW-1:0] box_high_z;
  } box_t;

  typedef struct packed {
    logic signed [CoordW-1:0] bound_low_x;
    logic signed [CoordW-1:0] bound_low_y;
    logic signed [CoordW-1:0] bound_low_z;
    logic signed [CoordW-1:0] bound_high_x;
    logic signed [CoordW-1:0] bound_high_y;
    logic signed [CoordW-1:0] bound_high_z;
  } bound_t;

endpackage

/* design/transformed_box_bounds_unit.sv */
// ----------------------------------------------------------------------------
// transformed_box_bounds_unit: running bounds of affinely transformed boxes
// Transforms each incoming box by a configured affine map and folds the
// transformed extent into running per-axis minimum and maximum bounds.
// ----------------------------------------------------------------------------
//  channel | valid       | ready       | payload                  | direction
//  --------+-------------+-------------+--------------------------+----------
//  box     | box_valid   | box_ready   | box (tbb_pkg::box_t)     | in
//  bound   | bound_valid | bound_ready | bound (tbb_pkg::bound_t) | out
//  cfg     | cfg_valid   | cfg_ready   | cfg_index, cfg_data      | in
//
// One box is accepted per cycle while box_ready is high. The bound request
// for a box passes through the input register, loaded by the accepting edge,
// then the product register, the sum register and the running bound
// register, the last also serving as the output register.
// Every stage holds when the stage after it is full and not moving, so a
// stall on the bound side backs up into box_ready. Reset (rst, synchronous)
// empties the pipeline, drops the held bounds and restores the identity
// transform. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module transformed_box_bounds_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                box_valid,
  output logic                                box_ready,
  input  tbb_pkg::box_t                       box,
  output logic                                bound_valid,
  input  logic                                bound_ready,
  output tbb_pkg::bound_t                     bound,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbb_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [tbb_pkg::RowW-1:0]            cfg_data
);

  localparam int CoordW   = tbb_pkg::CoordW;
  localparam int CoefW    = tbb_pkg::CoefW;
  localparam int ProdW    = tbb_pkg::ProdW;
  localparam int SumW     = tbb_pkg::SumW;
  localparam int ShiftedW = tbb_pkg::ShiftedW;
  localparam int Axes     = tbb_pkg::Axes;

  // Configuration registers.
  logic [tbb_pkg::RowW-1:0] row_coeffs [Axes];
  logic signed [CoordW-1:0] offsets    [Axes];

  // Pipeline registers.
  logic                     v1;
  logic                     start1;
  logic signed [CoordW-1:0] lo1 [Axes];
  logic signed [CoordW-1:0] hi1 [Axes];

  logic                     v2;
  logic                     start2;
  logic signed [ProdW-1:0]  prod_lo [Axes][Axes];
  logic signed [ProdW-1:0]  prod_hi [Axes][Axes];

  logic                     v3;
  logic                     start3;
  logic signed [SumW-1:0]   sum_min [Axes];
  logic signed [SumW-1:0]   sum_max [Axes];

  logic                     have_bounds;
  logic signed [CoordW-1:0] running_min [Axes];
  logic signed [CoordW-1:0] running_max [Axes];

  // Next values.
  logic signed [ProdW-1:0]  prod_lo_next [Axes][Axes];
  logic signed [ProdW-1:0]  prod_hi_next [Axes][Axes];
  logic signed [SumW-1:0]   sum_min_next [Axes];
  logic signed [SumW-1:0]   sum_max_next [Axes];
  logic signed [CoordW-1:0] running_min_next [Axes];
  logic signed [CoordW-1:0] running_max_next [Axes];

  logic en1, en2, en3, load_out;

  // Round half up from Q20.30 to Q16.16, then saturate to 32 bits.
  function automatic logic signed [CoordW-1:0] to_q16(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0]     t;
    logic signed [ShiftedW-1:0] q;
    logic                       over;
    logic                       under;
    t = s + SumW'(1 << (tbb_pkg::CoefFrac - 1));
    q = ShiftedW'(t >>> tbb_pkg::CoefFrac);
    over  = !q[ShiftedW-1] && (q[ShiftedW-2:CoordW-1] != '0);
    under = q[ShiftedW-1] && (q[ShiftedW-2:CoordW-1] != '1);
    if (over) begin
      to_q16 = {1'b0, {(CoordW-1){1'b1}}};
    end else if (under) begin
      to_q16 = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      to_q16 = q[CoordW-1:0];
    end
  endfunction

  // Stage enables: a stage loads when it is empty or its content moves on.
  assign load_out  = v3 && (!bound_valid || bound_ready);
  assign en3       = !v3 || load_out;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign box_ready = en1;
  assign cfg_ready = 1'b1;

  // Products of every coefficient with both corner coordinates.
  always_comb begin
    for (int r = 0; r < Axes; r++) begin
      for (int c = 0; c < Axes; c++) begin
        prod_lo_next[r][c] = ProdW'($signed(row_coeffs[r][c*CoefW +: CoefW]) * lo1[c]);
        prod_hi_next[r][c] = ProdW'($signed(row_coeffs[r][c*CoefW +: CoefW]) * hi1[c]);
      end
    end
  end

  // Per-term minima and maxima summed with the offset; this equals the
  // extremes over all eight corners since each term varies independently.
  always_comb begin
    for (int r = 0; r < Axes; r++) begin
      sum_min_next[r] = SumW'(offsets[r]) <<< tbb_pkg::CoefFrac;
      sum_max_next[r] = SumW'(offsets[r]) <<< tbb_pkg::CoefFrac;
      for (int c = 0; c < Axes; c++) begin
        if (prod_lo[r][c] < prod_hi[r][c]) begin
          sum_min_next[r] = sum_min_next[r] + SumW'(prod_lo[r][c]);
          sum_max_next[r] = sum_max_next[r] + SumW'(prod_hi[r][c]);
        end else begin
          sum_min_next[r] = sum_min_next[r] + SumW'(prod_hi[r][c]);
          sum_max_next[r] = sum_max_next[r] + SumW'(prod_lo[r][c]);
        end
      end
    end
  end

  // Fold the new extent into the running bounds.
  always_comb begin
    logic signed [CoordW-1:0] vmin;
    logic signed [CoordW-1:0] vmax;
    logic                     fresh;
    fresh = start3 || !have_bounds;
    for (int r = 0; r < Axes; r++) begin
      vmin = to_q16(sum_min[r]);
      vmax = to_q16(sum_max[r]);
      running_min_next[r] = (fresh || vmin < running_min[r]) ? vmin : running_min[r];
      running_max_next[r] = (fresh || vmax > running_max[r]) ? vmax : running_max[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_coeffs[0] <= tbb_pkg::RowXReset;
      row_coeffs[1] <= tbb_pkg::RowYReset;
      row_coeffs[2] <= tbb_pkg::RowZReset;
      for (int r = 0; r < Axes; r++) begin
        offsets[r] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tbb_pkg::CFG_ROW_X:    row_coeffs[0] <= cfg_data;
        tbb_pkg::CFG_ROW_Y:    row_coeffs[1] <= cfg_data;
        tbb_pkg::CFG_ROW_Z:    row_coeffs[2] <= cfg_data;
        tbb_pkg::CFG_OFFSET_X: offsets[0]    <= cfg_data[CoordW-1:0];
        tbb_pkg::CFG_OFFSET_Y: offsets[1]    <= cfg_data[CoordW-1:0];
        tbb_pkg::CFG_OFFSET_Z: offsets[2]    <= cfg_data[CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      bound_valid <= 1'b0;
      have_bounds <= 1'b0;
      for (int r = 0; r < Axes; r++) begin
        running_min[r] <= '0;
        running_max[r] <= '0;
      end
    end else begin
      if (en1) begin
        v1 <= box_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (load_out) begin
        bound_valid <= 1'b1;
        have_bounds <= 1'b1;
        running_min <= running_min_next;
        running_max <= running_max_next;
      end else if (bound_ready) begin
        bound_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1) begin
      start1 <= box.start_new;
      lo1[0] <= box.box_low_x;
      lo1[1] <= box.box_low_y;
      lo1[2] <= box.box_low_z;
      hi1[0] <= box.box_high_x;
      hi1[1] <= box.box_high_y;
      hi1[2] <= box.box_high_z;
    end
    if (en2) begin
      start2  <= start1;
      prod_lo <= prod_lo_next;
      prod_hi <= prod_hi_next;
    end
    if (en3) begin
      start3  <= start2;
      sum_min <= sum_min_next;
      sum_max <= sum_max_next;
    end
  end

  always_comb begin
    bound.bound_low_x  = running_min[0];
    bound.bound_low_y  = running_min[1];
    bound.bound_low_z  = running_min[2];
    bound.bound_high_x = running_max[0];
    bound.bound_high_y = running_max[1];
    bound.bound_high_z = running_max[2];
  end

endmodule
